@@ sv/spi_master_frame_engine_defines.svh @@
// Assertion macros shared by the SPI master frame engine RTL.
`ifndef SPI_MASTER_FRAME_ENGINE_DEFINES_SVH
`define SPI_MASTER_FRAME_ENGINE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SFE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must be followed by another in the same cycle.
`define SFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ sv/sfe_pkg.sv @@
// Package of types, constants and lookup functions for the SPI master frame engine.
package sfe_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int RECEIVE_DEPTH = 4;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RPTR_W  = (RECEIVE_DEPTH > 1) ? $clog2(RECEIVE_DEPTH) : 1;
  localparam int RFILL_W = $clog2(RECEIVE_DEPTH + 1);
  localparam int FRAME_W = 22;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_ATTR0    = 2'd0;
  localparam logic [1:0] REG_ATTR1    = 2'd1;
  localparam logic [1:0] REG_HALTED   = 2'd2;
  localparam logic [1:0] REG_CLOCK_ON = 2'd3;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_PUSH_TX  = 3'd1,
    OP_PUSH_WR  = 3'd2,
    OP_POP_RX   = 3'd3,
    OP_POP_WT   = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_LOAD,
    S_RUN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [31:0] attr_zero;
    logic [31:0] attr_one;
    logic        halted;
    logic        clock_on;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] data_out;
    logic [15:0] command;
    logic [2:0]  flags;
    logic [15:0] transfer_count;
    logic [15:0] last_received;
    logic [4:0]  transmit_level;
  } res_t;

  // Prescaler values {2, 3, 5, 7}.
  function automatic logic [2:0] prescale_f(input logic [1:0] sel);
    logic [2:0] v;
    unique case (sel)
      2'd0: v = 3'd2;
      2'd1: v = 3'd3;
      2'd2: v = 3'd5;
      default: v = 3'd7;
    endcase
    return v;
  endfunction

  // Baud scaler values: 2, 4, 6, 8, then powers of two up to 32768.
  function automatic logic [15:0] scaler_f(input logic [3:0] sel);
    logic [15:0] v;
    if (sel == 4'd2) begin
      v = 16'd6;
    end else if (sel < 4'd2) begin
      v = 16'd2 << sel;
    end else begin
      v = 16'd1 << sel;
    end
    return v;
  endfunction

  function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  function automatic logic [RPTR_W-1:0] rptr_inc(input logic [RPTR_W-1:0] p);
    return (p == RPTR_W'(RECEIVE_DEPTH - 1)) ? '0 : p + RPTR_W'(1);
  endfunction

endpackage

@@ sv/sfe_regs.sv @@
// APB configuration registers of the SPI master frame engine.
module sfe_regs
  import sfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // Register writes on the access phase of a write transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attr_zero <= '0;
      cfg_q.attr_one  <= '0;
      cfg_q.halted    <= 1'b1;
      cfg_q.clock_on  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ATTR0:    cfg_q.attr_zero <= pwdata;
        REG_ATTR1:    cfg_q.attr_one  <= pwdata;
        REG_HALTED:   cfg_q.halted    <= pwdata[0];
        default:      cfg_q.clock_on  <= pwdata[0];
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[3:2])
      REG_ATTR0:  prdata = cfg_q.attr_zero;
      REG_ATTR1:  prdata = cfg_q.attr_one;
      REG_HALTED: prdata = {31'd0, cfg_q.halted};
      default:    prdata = {31'd0, cfg_q.clock_on};
    endcase
  end

endmodule

@@ sv/sfe_frame_calc.sv @@
// Two-stage multiplier that turns an attribute set into a frame time in bus cycles.
module sfe_frame_calc
  import sfe_pkg::*;
(
  input  logic               clk_i,
  input  logic [31:0]        attr_i,
  output logic [FRAME_W-1:0] frame_time_o
);

  logic [18:0]        cyc_full;
  logic [17:0]        cyc_q;
  logic [4:0]         bits_q;
  logic [FRAME_W:0]   prod;
  logic [FRAME_W-1:0] frame_q;

  assign cyc_full = 19'(prescale_f(attr_i[17:16]) * scaler_f(attr_i[3:0]));

  // First stage: prescaler times scaler, halved at double rate.
  always_ff @(posedge clk_i) begin
    cyc_q  <= attr_i[31] ? cyc_full[18:1] : cyc_full[17:0];
    bits_q <= {1'b0, attr_i[30:27]} + 5'd1;
  end

  // Second stage: times the frame size.
  assign prod = (FRAME_W+1)'(cyc_q * bits_q);

  always_ff @(posedge clk_i) begin
    frame_q <= prod[FRAME_W-1:0];
  end

  assign frame_time_o = frame_q;

endmodule

@@ sv/spi_master_frame_engine.sv @@
// Push, pop and clear-flags transactions pass through the finish state to the result handshake.
// A tick works through the frames in turn: for each frame it loads, a check, two multiply stages,
// a load and a count-down step; for a frame already under way, a check and a count-down step.
// One item is worked on at a time; a finished result waits in an output register while
// the next item is taken. Reset is asynchronous and active low: queues empty, halted set,
// clock gate off, counters and flags cleared; queue storage is not cleared.
module spi_master_frame_engine
  import sfe_pkg::*;
`include "spi_master_frame_engine_defines.svh"
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] bus_cycles_i,
  input  logic [15:0] data_word_i,
  input  logic [15:0] command_word_i,
  input  logic [2:0]  clear_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [15:0] data_out_o,
  output logic [5:0]  select_lines_o,
  output logic [2:0]  attribute_set_o,
  output logic        continuous_select_o,
  output logic        last_marker_o,
  output logic        complete_flag_o,
  output logic        queue_end_flag_o,
  output logic        overflow_flag_o,
  output logic [15:0] transfer_count_o,
  output logic [15:0] last_received_o,
  output logic [4:0]  transmit_level_o
);

  cfg_t cfg;
  state_e state_q, state_d;

  // Queue storage and pointers.
  logic [31:0] tx_mem [QUEUE_DEPTH];
  logic [15:0] wr_mem [QUEUE_DEPTH];
  logic [15:0] rx_mem [RECEIVE_DEPTH];
  logic [31:0] wt_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  tx_head_q, tx_tail_q, wr_head_q, wr_tail_q, wt_head_q, wt_tail_q;
  logic [QFILL_W-1:0] tx_fill_q, wr_fill_q, wt_fill_q;
  logic [RPTR_W-1:0]  rx_head_q, rx_tail_q;
  logic [RFILL_W-1:0] rx_fill_q;

  logic [FRAME_W-1:0] rem_q, frame_time, elapsed;
  logic [31:0]        cycles_q;
  logic [2:0]         flags_q;
  logic [15:0]        count_q, latch_q;
  logic               acc_q;
  logic [15:0]        dout_q, pcmd_q;
  res_t               out_q;
  logic               out_valid_q;
  logic [31:0]        tx_rd_q;
  logic [15:0]        wr_rd_q;

  logic        is_acc, tx_we, wr_we, rx_we, wt_we, frame_end, out_load;
  logic        tx_full, wr_full, wt_full, rx_full, tick_go;
  logic [31:0] tx_head_entry;
  logic [31:0] attr_sel;
  logic [15:0] word;
  op_e         op;

  sfe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Attribute set chosen by the command of the head transmit entry.
  assign tx_head_entry = tx_rd_q;
  assign attr_sel = (tx_head_entry[30:28] != 3'd0) ? cfg.attr_one : cfg.attr_zero;

  sfe_frame_calc u_calc (
    .clk_i        (clk_i),
    .attr_i       (attr_sel),
    .frame_time_o (frame_time)
  );

  assign op      = op_e'(operation_i);
  assign is_acc  = in_valid_i & in_ready_o;
  assign tx_full = (tx_fill_q == QFILL_W'(QUEUE_DEPTH));
  assign wr_full = (wr_fill_q == QFILL_W'(QUEUE_DEPTH));
  assign wt_full = (wt_fill_q == QFILL_W'(QUEUE_DEPTH));
  assign rx_full = (rx_fill_q == RFILL_W'(RECEIVE_DEPTH));
  assign tick_go = (cycles_q != 32'd0) && cfg.clock_on && !cfg.halted &&
                   (tx_fill_q != '0);

  // Shared compare/subtract step of the count-down.
  assign frame_end = (state_q == S_RUN) && (cycles_q >= {10'd0, rem_q});
  assign elapsed   = frame_end ? rem_q : cycles_q[FRAME_W-1:0];
  assign word      = (wr_fill_q != '0) ? wr_rd_q : 16'hffff;

  assign tx_we = is_acc && (op == OP_PUSH_TX) && !tx_full;
  assign wr_we = is_acc && (op == OP_PUSH_WR) && !wr_full;
  assign wt_we = frame_end && !wt_full;
  assign rx_we = frame_end && !rx_full;

  // Sequencer: next state and handshake.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (op == OP_TICK) ? S_CHECK : S_FINISH;
        end
      end
      S_CHECK: begin
        if (!tick_go) begin
          state_d = S_FINISH;
        end else if (rem_q == '0) begin
          state_d = S_MUL1;
        end else begin
          state_d = S_RUN;
        end
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_LOAD;
      S_LOAD:  state_d = S_RUN;
      S_RUN:   state_d = S_CHECK;
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Queue storage writes, and the head entry and wire receive word read at each check step.
  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_tail_q] <= {command_word_i, data_word_i};
    end
    if (wr_we) begin
      wr_mem[wr_tail_q] <= data_word_i;
    end
    if (wt_we) begin
      wt_mem[wt_tail_q] <= tx_head_entry;
    end
    if (rx_we) begin
      rx_mem[rx_tail_q] <= word;
    end
    if (state_q == S_CHECK) begin
      tx_rd_q <= tx_mem[tx_head_q];
      wr_rd_q <= wr_mem[wr_head_q];
    end
  end

  // Queue pointers, fills, counters and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q <= '0; tx_tail_q <= '0; tx_fill_q <= '0;
      wr_head_q <= '0; wr_tail_q <= '0; wr_fill_q <= '0;
      wt_head_q <= '0; wt_tail_q <= '0; wt_fill_q <= '0;
      rx_head_q <= '0; rx_tail_q <= '0; rx_fill_q <= '0;
      rem_q     <= '0;
      cycles_q  <= '0;
      flags_q   <= '0;
      count_q   <= '0;
      latch_q   <= '0;
      acc_q     <= 1'b0;
      dout_q    <= '0;
      pcmd_q    <= '0;
    end else begin
      if (is_acc) begin
        cycles_q <= bus_cycles_i;
        acc_q    <= 1'b0;
        dout_q   <= '0;
        pcmd_q   <= '0;
        unique case (op)
          OP_PUSH_TX: begin
            acc_q <= !tx_full;
            if (!tx_full) begin
              tx_tail_q <= qptr_inc(tx_tail_q);
              tx_fill_q <= tx_fill_q + QFILL_W'(1);
            end
          end
          OP_PUSH_WR: begin
            acc_q <= !wr_full;
            if (!wr_full) begin
              wr_tail_q <= qptr_inc(wr_tail_q);
              wr_fill_q <= wr_fill_q + QFILL_W'(1);
            end
          end
          OP_POP_RX: begin
            if (rx_fill_q != '0) begin
              acc_q     <= 1'b1;
              dout_q    <= rx_mem[rx_head_q];
              rx_head_q <= rptr_inc(rx_head_q);
              rx_fill_q <= rx_fill_q - RFILL_W'(1);
            end
          end
          OP_POP_WT: begin
            if (wt_fill_q != '0) begin
              acc_q     <= 1'b1;
              dout_q    <= wt_mem[wt_head_q][15:0];
              pcmd_q    <= wt_mem[wt_head_q][31:16];
              wt_head_q <= qptr_inc(wt_head_q);
              wt_fill_q <= wt_fill_q - QFILL_W'(1);
            end
          end
          OP_CLEAR: flags_q <= flags_q & ~clear_mask_i;
          default: ;
        endcase
      end

      if (state_q == S_LOAD) begin
        rem_q <= frame_time;
      end

      // Count-down step and frame completion.
      if (state_q == S_RUN) begin
        cycles_q <= cycles_q - {10'd0, elapsed};
        rem_q    <= rem_q - elapsed;
      end
      if (frame_end) begin
        tx_head_q <= qptr_inc(tx_head_q);
        tx_fill_q <= tx_fill_q - QFILL_W'(1);
        if (wr_fill_q != '0) begin
          wr_head_q <= qptr_inc(wr_head_q);
          wr_fill_q <= wr_fill_q - QFILL_W'(1);
        end
        if (!wt_full) begin
          wt_tail_q <= qptr_inc(wt_tail_q);
          wt_fill_q <= wt_fill_q + QFILL_W'(1);
        end
        if (!rx_full) begin
          rx_tail_q <= rptr_inc(rx_tail_q);
          rx_fill_q <= rx_fill_q + RFILL_W'(1);
        end
        latch_q <= word;
        count_q <= count_q + 16'd1;
        flags_q <= flags_q | {rx_full, tx_head_entry[27], 1'b1};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.accepted       <= acc_q;
      out_q.data_out       <= dout_q;
      out_q.command        <= pcmd_q;
      out_q.flags          <= flags_q;
      out_q.transfer_count <= count_q;
      out_q.last_received  <= latch_q;
      out_q.transmit_level <= 5'(tx_fill_q);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accepted_o          = out_q.accepted;
  assign data_out_o          = out_q.data_out;
  assign select_lines_o      = out_q.command[5:0];
  assign attribute_set_o     = out_q.command[14:12];
  assign continuous_select_o = out_q.command[15];
  assign last_marker_o       = out_q.command[11];
  assign complete_flag_o     = out_q.flags[0];
  assign queue_end_flag_o    = out_q.flags[1];
  assign overflow_flag_o     = out_q.flags[2];
  assign transfer_count_o    = out_q.transfer_count;
  assign last_received_o     = out_q.last_received;
  assign transmit_level_o    = out_q.transmit_level;

  // Checks on the sequencer and the queues.
  `SFE_ASSERT_ALWAYS(a_tx_fill_bound, tx_fill_q <= QFILL_W'(QUEUE_DEPTH), "transmit fill overrun")
  `SFE_ASSERT_ALWAYS(a_rx_fill_bound, rx_fill_q <= RFILL_W'(RECEIVE_DEPTH), "receive fill overrun")
  `SFE_ASSERT_IMPL(a_run_loaded, state_q == S_RUN, rem_q != '0 && tx_fill_q != '0, "count-down without a frame")

endmodule
